FILE: src/parity_gated_ring_buffer_macros.svh
// assertion helpers, sampled on clk_i and quiet while rst_ni is low
`ifndef PARITY_GATED_RING_BUFFER_MACROS_SVH
`define PARITY_GATED_RING_BUFFER_MACROS_SVH

// same-cycle implication
`define PGRB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PGRB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/pgrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pgrb_pkg;

  localparam int DEPTH  = 8;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int MIN_W  = 3;
  localparam int CMP_W  = (FILL_W > MIN_W) ? FILL_W : MIN_W;

  localparam logic [MIN_W-1:0] MIN_FILL_RESET = 3'd3;

  typedef enum logic [1:0] {
    OP_PUT      = 2'd0,
    OP_GET_EVEN = 2'd1,
    OP_GET_ODD  = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    KIND_EVEN   = 3'd0,
    KIND_ODD    = 3'd1,
    KIND_PARKED = 3'd2,
    KIND_FULL   = 3'd3,
    KIND_ACCEPT = 3'd4,
    KIND_DUP    = 3'd5
  } kind_e;

  typedef struct packed {
    opcode_e            op;
    logic signed [31:0] word;
  } cmd_t;

  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic              even_pending;
    logic              odd_pending;
  } stat_t;

endpackage
`default_nettype wire

FILE: src/parity_gated_ring_buffer.sv
// Ring FIFO of signed words shared by an even and an odd consumer class.
// Input stream: tuser carries the opcode (put, get even, get odd), tdata the
// word to append. Output stream: tuser carries the result kind, tdata the
// delivered word (zero for non-deliveries), tlast marks the final result of
// an item. Each item gives one to three results; opcode 3 gives none.
// min_fill is written through cfg_we_i / cfg_wdata_i; the user must write it
// only while the block is idle, which the block itself does not enforce. A
// two-entry command queue in the front feeds the sequencer, so items keep
// being taken while results wait on the output register. The first result of
// an item passes the command queue, the held result register and the output
// register. The sequencer executes an item in its idle state, then decides
// release and tlast in one check step per result before taking a new item.
// Reset empties the buffer, clears both pending gets and sets min_fill to 3.
// When the receiver holds tready low, the result in the output register holds,
// the sequencer waits, and input is taken until the command queue is full.
`timescale 1ns / 1ps
`default_nettype none
`include "parity_gated_ring_buffer_macros.svh"
module parity_gated_ring_buffer import pgrb_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [MIN_W-1:0]   cfg_wdata_i,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic signed [31:0] s_axis_tdata,   // word_in
  input  wire logic [1:0]         s_axis_tuser,   // opcode
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic signed [31:0]      m_axis_tdata,   // word_out
  output logic [2:0]              m_axis_tuser,   // kind
  output logic                    m_axis_tlast
);

  logic  cmd_valid, cmd_ready;
  cmd_t  cmd;
  stat_t stat;

  pgrb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_o         (cmd)
  );

  pgrb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_o   (cmd_ready),
    .cmd_i         (cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .stat_o        (stat)
  );

  // delivered word parity must match its class
  `PGRB_ASSERT_IMP(a_parity,
    m_axis_tvalid && (m_axis_tuser == KIND_EVEN || m_axis_tuser == KIND_ODD),
    m_axis_tdata[0] == m_axis_tuser[0], "delivery parity mismatch")
  // non-deliveries carry a zero word
  `PGRB_ASSERT_IMP(a_zero_word,
    m_axis_tvalid && m_axis_tuser != KIND_EVEN && m_axis_tuser != KIND_ODD,
    m_axis_tdata == '0, "non-delivery word not zero")
  // fill moves by at most one entry per cycle and never passes the depth
  `PGRB_ASSERT_NXT(a_fill_step, 1'b1,
    (stat.fill == $past(stat.fill)) || (stat.fill == $past(stat.fill) + 1'b1) ||
    (stat.fill == $past(stat.fill) - 1'b1), "fill jumped")
  `PGRB_ASSERT_IMP(a_fill_max, 1'b1, stat.fill <= FILL_W'(DEPTH), "fill beyond depth")

endmodule
`default_nettype wire

FILE: src/pgrb_front.sv
`timescale 1ns / 1ps
`default_nettype none
module pgrb_front import pgrb_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic signed [31:0] s_axis_tdata,   // word_in
  input  wire logic [1:0]         s_axis_tuser,   // opcode
  output logic                    cmd_valid_o,
  input  wire logic               cmd_ready_i,
  output cmd_t                    cmd_o
);

  cmd_t       q_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       op_ok, push, pop;

  // unused opcode is taken and dropped here
  assign op_ok = (s_axis_tuser == OP_PUT) || (s_axis_tuser == OP_GET_EVEN) ||
                 (s_axis_tuser == OP_GET_ODD);

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready && op_ok;
  assign cmd_valid_o   = (cnt_q != 2'd0);
  assign pop           = cmd_ready_i && cmd_valid_o;
  assign cmd_o         = q_q[rp_q];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wp_q] <= '{op: opcode_e'(s_axis_tuser), word: s_axis_tdata};
    end
  end

endmodule
`default_nettype wire

FILE: src/pgrb_back.sv
`timescale 1ns / 1ps
`default_nettype none
module pgrb_back import pgrb_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [MIN_W-1:0]   cfg_wdata_i,
  input  wire logic               cmd_valid_i,
  output logic                    cmd_ready_o,
  input  wire cmd_t               cmd_i,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic signed [31:0]      m_axis_tdata,   // word_out
  output logic [2:0]              m_axis_tuser,   // kind
  output logic                    m_axis_tlast,
  output stat_t                   stat_o
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_CHECK = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [PTR_W-1:0]   rd_q, rd_d, wr_q, wr_d, rd_inc, wr_inc;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic               ep_q, ep_d, op_q, op_d;
  logic [1:0]         cnt_q, cnt_d;
  kind_e              h_kind_q, h_kind_d;
  logic signed [31:0] h_word_q, h_word_d;
  logic [MIN_W-1:0]   min_q, min_d;
  logic signed [31:0] slots_q [DEPTH];
  logic               slot_we;
  logic               out_valid_q, out_valid_d, out_last_q, out_last_d;
  kind_e              out_kind_q, out_kind_d;
  logic signed [31:0] out_word_q, out_word_d;
  logic signed [31:0] head;
  logic               head_odd, avail, oready, rel, want_odd, pend;

  assign head     = slots_q[rd_q];
  assign head_odd = head[0];
  assign avail    = (CMP_W'(fill_q) > CMP_W'(min_q)) && (fill_q != '0);
  assign rd_inc   = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
  assign wr_inc   = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
  assign oready   = !out_valid_q || m_axis_tready;
  assign want_odd = (cmd_i.op == OP_GET_ODD);
  assign pend     = want_odd ? op_q : ep_q;
  assign rel      = (cnt_q != 2'd2) && avail && (head_odd ? op_q : ep_q);

  always_comb begin
    state_d     = state_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    fill_d      = fill_q;
    ep_d        = ep_q;
    op_d        = op_q;
    cnt_d       = cnt_q;
    h_kind_d    = h_kind_q;
    h_word_d    = h_word_q;
    min_d       = cfg_we_i ? cfg_wdata_i : min_q;
    slot_we     = 1'b0;
    cmd_ready_o = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_word_d  = out_word_q;
    out_last_d  = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          state_d  = ST_CHECK;
          h_word_d = '0;
          cnt_d    = 2'd0;
          unique case (cmd_i.op)
            OP_PUT: begin
              if (fill_q == FILL_W'(DEPTH)) begin
                h_kind_d = KIND_FULL;
                cnt_d    = 2'd2;
              end else begin
                slot_we  = 1'b1;
                wr_d     = wr_inc;
                fill_d   = fill_q + 1'b1;
                h_kind_d = KIND_ACCEPT;
              end
            end
            OP_GET_EVEN, OP_GET_ODD: begin
              if (pend) begin
                h_kind_d = KIND_DUP;
                cnt_d    = 2'd2;
              end else if (avail && (head_odd == want_odd)) begin
                h_kind_d = want_odd ? KIND_ODD : KIND_EVEN;
                h_word_d = head;
                rd_d     = rd_inc;
                fill_d   = fill_q - 1'b1;
              end else begin
                if (want_odd) op_d = 1'b1;
                else          ep_d = 1'b1;
                h_kind_d = KIND_PARKED;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        if (oready) begin
          out_valid_d = 1'b1;
          out_kind_d  = h_kind_q;
          out_word_d  = h_word_q;
          out_last_d  = !rel;
          if (rel) begin
            if (head_odd) op_d = 1'b0;
            else          ep_d = 1'b0;
            h_kind_d = head_odd ? KIND_ODD : KIND_EVEN;
            h_word_d = head;
            rd_d     = rd_inc;
            fill_d   = fill_q - 1'b1;
            cnt_d    = cnt_q + 1'b1;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_q        <= '0;
      wr_q        <= '0;
      fill_q      <= '0;
      ep_q        <= 1'b0;
      op_q        <= 1'b0;
      cnt_q       <= 2'd0;
      min_q       <= MIN_FILL_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      fill_q      <= fill_d;
      ep_q        <= ep_d;
      op_q        <= op_d;
      cnt_q       <= cnt_d;
      min_q       <= min_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_kind_q   <= h_kind_d;
    h_word_q   <= h_word_d;
    out_kind_q <= out_kind_d;
    out_word_q <= out_word_d;
    out_last_q <= out_last_d;
    if (slot_we) begin
      slots_q[wr_q] <= cmd_i.word;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_word_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign stat_o        = '{fill: fill_q, even_pending: ep_q, odd_pending: op_q};

endmodule
`default_nettype wire
